[sv/mesi_snooping_l1_cache_macros.svh]
// Assertion macros for the MESI snooping L1 cache checker.
// No dependencies.
`ifndef MESI_SNOOPING_L1_CACHE_MACROS_SVH
`define MESI_SNOOPING_L1_CACHE_MACROS_SVH

// property checked on every clock edge out of reset
`define MSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication from a trigger to a condition in the same cycle
`define MSC_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

`endif

[sv/msc_pkg.sv]
// Package for the MESI snooping L1 cache: payload structs, codes, defaults.
// No dependencies.
`default_nettype none
package msc_pkg;
    localparam int SET_COUNT_DEF  = 64;
    localparam int LINE_WORDS_DEF = 8;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_BUS   = 3'd2;
    localparam logic [2:0] ACT_GRANT = 3'd3;
    localparam logic [2:0] ACT_FILL  = 3'd4;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_READX = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] address;
        logic [31:0] write_word;
        logic [1:0]  bus_command;
        logic [31:0] bus_address;
        logic [31:0] bus_word;
        logic        bus_shared_seen;
        logic [1:0]  bus_origin;
    } msc_in_t;

    typedef struct packed {
        logic        access_done;
        logic [31:0] read_word;
        logic        drive_flush;
        logic [31:0] drive_address;
        logic [31:0] drive_word;
        logic        assert_shared;
        logic        bus_hold;
        logic        eviction_request;
        logic        miss_pending;
        logic [31:0] miss_line_address;
        logic        miss_exclusive;
    } msc_out_t;
endpackage
`default_nettype wire

[sv/mesi_snooping_l1_cache.sv]
// Top level of the MESI snooping L1 cache: handshake, sequencer, memories.
// Depends on msc_pkg.
`default_nettype none
// Direct-mapped MESI L1 cache. After acceptance a beat passes through the RD
// and EXE phases before the next accept. The tag/state and data memories are
// read at the accepting edge (synchronous read). The RD phase only holds the
// registered read data. The EXE phase computes, writes back and loads the
// output register. A new beat is taken only when the output register is empty
// or being emptied that cycle.
// Data memory is SET_COUNT*LINE_WORDS words, tag/state memory SET_COUNT
// entries. After reset a clearing pass over every data word zeroes
// the data memory and invalidates the tag/state memory; no beat is taken
// during it.
module mesi_snooping_l1_cache #(
    parameter int SET_COUNT  = msc_pkg::SET_COUNT_DEF,
    parameter int LINE_WORDS = msc_pkg::LINE_WORDS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire msc_pkg::msc_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output msc_pkg::msc_out_t     m_data
);
    import msc_pkg::*;

    localparam int WB = $clog2(LINE_WORDS);
    localparam int SB = $clog2(SET_COUNT);
    localparam int TB = 32 - WB - SB;
    localparam int AB = WB + SB;
    localparam logic [WB-1:0] LAST_W = WB'(LINE_WORDS - 1);

    typedef enum logic [3:0] {
        PH_CLR  = 4'b0001,
        PH_IDLE = 4'b0010,
        PH_RD   = 4'b0100,
        PH_EXE  = 4'b1000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic [AB-1:0] clr_reg;
    logic [1:0] own_id_reg;
    msc_in_t in_reg;

    logic [31:0]   data_mem [SET_COUNT*LINE_WORDS];
    logic [TB+1:0] tag_mem  [SET_COUNT];
    logic [31:0]   drd_reg;
    logic [TB+1:0] trd_reg;

    logic [31:0] pend_addr_reg;
    logic        pend_v_reg;
    logic [31:0] fbase_reg;
    logic [WB-1:0] fcnt_reg;
    logic        wex_reg, fshared_reg, await_reg, flushing_reg, victim_reg, tcw_reg;

    logic        out_v_reg;
    msc_out_t    out_reg;

    // memory write port
    logic          dwe, twe;
    logic [AB-1:0] dwa;
    logic [31:0]   dwd;
    logic [SB-1:0] twa;
    logic [TB+1:0] twd;

    // read address selection
    logic [31:0]   ra;
    logic [SB-1:0] rset;
    logic [WB-1:0] rword;

    assign s_ready = (phase_reg == PH_IDLE) && (!out_v_reg || m_ready);
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    always_comb begin
        if (s_data.action == ACT_BUS && flushing_reg) begin
            ra = fbase_reg;
            rword = fcnt_reg;
        end else if (s_data.action == ACT_BUS) begin
            ra = s_data.bus_address;
            rword = ra[WB-1:0];
        end else begin
            ra = s_data.address;
            rword = ra[WB-1:0];
        end
        rset = ra[AB-1:WB];
    end

    always_ff @(posedge aclk) begin
        if (dwe) data_mem[dwa] <= dwd;
        if (twe) tag_mem[twa] <= twd;
        if (s_valid && s_ready) begin
            drd_reg <= data_mem[{rset, rword}];
            trd_reg <= tag_mem[rset];
            in_reg  <= s_data;
        end
    end

    // execute stage
    logic [31:0]   a, ba;
    logic [SB-1:0] aset, bset, fset;
    logic [TB-1:0] atag, btag, ctag;
    logic [1:0]    cst;
    msc_out_t      o;
    logic [31:0]   pend_addr_n, fbase_n;
    logic [WB-1:0] fcnt_n;
    logic pend_v_n, wex_n, fshared_n, await_n, flushing_n, victim_n, tcw_n;

    always_comb begin
        a    = in_reg.address;
        ba   = in_reg.bus_address;
        aset = a[AB-1:WB];
        bset = ba[AB-1:WB];
        fset = fbase_reg[AB-1:WB];
        atag = a[31:AB];
        btag = ba[31:AB];
        ctag = trd_reg[TB+1:2];
        cst  = trd_reg[1:0];
        o = '0;
        dwe = 1'b0; dwa = '0; dwd = '0;
        twe = 1'b0; twa = '0; twd = '0;
        pend_addr_n = pend_addr_reg; pend_v_n = pend_v_reg;
        fbase_n = fbase_reg; fcnt_n = fcnt_reg; wex_n = wex_reg;
        fshared_n = fshared_reg; await_n = await_reg; flushing_n = flushing_reg;
        victim_n = victim_reg; tcw_n = tcw_reg;
        if (phase_reg == PH_CLR) begin
            dwe = 1'b1; dwa = clr_reg; dwd = '0;
            twe = 1'b1; twa = clr_reg[AB-1:WB]; twd = '0;
        end else if (phase_reg == PH_EXE) begin
            case (in_reg.action)
                ACT_READ: begin
                    if (cst != ST_I && ctag == atag) begin
                        if (pend_v_reg && pend_addr_reg == a) pend_v_n = 1'b0;
                        o.access_done = 1'b1;
                        o.read_word = drd_reg;
                        tcw_n = 1'b0;
                    end else if (cst == ST_M) begin
                        if (!victim_reg && !flushing_reg) begin
                            victim_n = 1'b1;
                            fbase_n = {ctag, aset, WB'(0)};
                            fcnt_n = '0;
                        end
                    end else if (!(pend_v_reg && pend_addr_reg == a)) begin
                        if (!tcw_reg) begin
                            tcw_n = 1'b1;
                        end else begin
                            wex_n = 1'b0; pend_addr_n = a; pend_v_n = 1'b1;
                            fshared_n = 1'b0; tcw_n = 1'b0;
                        end
                    end
                end
                ACT_WRITE: begin
                    if ((cst == ST_M || cst == ST_E) && ctag == atag) begin
                        if (pend_v_reg && pend_addr_reg == a) pend_v_n = 1'b0;
                        dwe = 1'b1; dwa = a[AB-1:0]; dwd = in_reg.write_word;
                        twe = 1'b1; twa = aset; twd = {ctag, ST_M};
                        tcw_n = 1'b0;
                        o.access_done = 1'b1;
                    end else if (cst == ST_M) begin
                        if (!victim_reg && !flushing_reg) begin
                            victim_n = 1'b1;
                            fbase_n = {ctag, aset, WB'(0)};
                            fcnt_n = '0;
                        end
                    end else if (!wex_reg && !tcw_reg) begin
                        tcw_n = 1'b1;
                    end else begin
                        if (!wex_reg && !(pend_v_reg && pend_addr_reg == a)) tcw_n = 1'b0;
                        wex_n = 1'b1; pend_addr_n = a; pend_v_n = 1'b1;
                    end
                end
                ACT_BUS: begin
                    if (flushing_reg) begin
                        o.drive_flush = 1'b1;
                        o.drive_address = fbase_reg + 32'(fcnt_reg);
                        o.drive_word = drd_reg;
                        o.assert_shared = 1'b1;
                        fcnt_n = fcnt_reg + 1'b1;
                        if (fcnt_reg == LAST_W) begin
                            flushing_n = 1'b0;
                            if (cst == ST_M) begin
                                twe = 1'b1; twa = fset; twd = {ctag, ST_I};
                            end
                        end
                    end else begin
                        if ((in_reg.bus_command == CMD_READ ||
                             in_reg.bus_command == CMD_READX) &&
                            in_reg.bus_origin != own_id_reg &&
                            cst != ST_I && ctag == btag) begin
                            if (in_reg.bus_command == CMD_READ && cst != ST_M)
                                o.assert_shared = 1'b1;
                            if (cst == ST_M) begin
                                flushing_n = 1'b1;
                                fbase_n = {ba[31:WB], WB'(0)};
                                fcnt_n = '0;
                            end
                            if (cst != ST_S || in_reg.bus_command == CMD_READX) begin
                                twe = 1'b1; twa = bset;
                                twd = {ctag, (in_reg.bus_command == CMD_READ) ? ST_S : ST_I};
                            end
                        end
                        if (in_reg.bus_command == CMD_FLUSH) begin
                            if (in_reg.bus_shared_seen) fshared_n = 1'b1;
                            if (await_reg && pend_v_reg &&
                                ba[31:WB] == pend_addr_reg[31:WB]) begin
                                dwe = 1'b1; dwa = ba[AB-1:0]; dwd = in_reg.bus_word;
                                if (ba[WB-1:0] == LAST_W) begin
                                    await_n = 1'b0;
                                    twe = 1'b1; twa = bset;
                                    if (wex_reg) begin
                                        twd = {btag, ST_M}; wex_n = 1'b0;
                                    end else begin
                                        twd = {btag, fshared_n ? ST_S : ST_E};
                                    end
                                end
                            end
                        end
                    end
                end
                ACT_GRANT: begin
                    if (victim_reg && !flushing_reg) begin
                        victim_n = 1'b0; flushing_n = 1'b1; fcnt_n = '0;
                    end
                end
                ACT_FILL: begin
                    if (pend_v_reg) await_n = 1'b1;
                end
                default: begin
                end
            endcase
            o.bus_hold = flushing_n;
            o.eviction_request = victim_n;
            o.miss_pending = pend_v_n;
            o.miss_line_address = pend_v_n ? pend_addr_n : '0;
            o.miss_exclusive = pend_v_n && wex_n;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_CLR:  if (clr_reg == AB'(SET_COUNT*LINE_WORDS - 1)) phase_next = PH_IDLE;
            PH_IDLE: if (s_valid && s_ready) phase_next = PH_RD;
            PH_RD:   phase_next = PH_EXE;
            PH_EXE:  phase_next = PH_IDLE;
            default: phase_next = PH_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CLR;
            clr_reg <= '0;
            own_id_reg <= '0;
            pend_addr_reg <= '0; pend_v_reg <= 1'b0;
            fbase_reg <= '0; fcnt_reg <= '0;
            wex_reg <= 1'b0; fshared_reg <= 1'b0; await_reg <= 1'b0;
            flushing_reg <= 1'b0; victim_reg <= 1'b0; tcw_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (phase_reg == PH_CLR) clr_reg <= clr_reg + 1'b1;
            if (cfg_we) own_id_reg <= cfg_wdata;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (phase_reg == PH_EXE) begin
                pend_addr_reg <= pend_addr_n; pend_v_reg <= pend_v_n;
                fbase_reg <= fbase_n; fcnt_reg <= fcnt_n;
                wex_reg <= wex_n; fshared_reg <= fshared_n; await_reg <= await_n;
                flushing_reg <= flushing_n; victim_reg <= victim_n; tcw_reg <= tcw_n;
                out_v_reg <= 1'b1;
                out_reg <= o;
            end
        end
    end
endmodule
`default_nettype wire

[sv/msc_checker.sv]
// Port-level checker for the MESI snooping L1 cache, bound to the top level.
// Depends on msc_pkg and mesi_snooping_l1_cache_macros.svh.
`default_nettype none
`include "mesi_snooping_l1_cache_macros.svh"
module msc_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire msc_pkg::msc_out_t m_data
);
    import msc_pkg::*;

    `MSC_IMPLY(a_stall_hold, m_valid && !m_ready, ##1 (m_valid && $stable(m_data)), "result beat dropped while stalled")
    `MSC_IMPLY(a_flush_hold, m_valid && m_data.drive_flush, m_data.assert_shared, "flush word without shared")
    `MSC_IMPLY(a_miss_addr, m_valid && !m_data.miss_pending, m_data.miss_line_address == '0 && !m_data.miss_exclusive, "miss fields without pending miss")
    `MSC_IMPLY(a_done_clean, m_valid && m_data.access_done, !m_data.drive_flush, "core hit and flush together")
    `MSC_IMPLY(a_one_beat, s_valid && s_ready, ##1 !s_ready, "second beat taken while busy")
endmodule

bind mesi_snooping_l1_cache msc_checker u_msc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire
